### rtl/sxc_pkg.sv
// shared types, constants and helper functions for the s-expression structure checker
`default_nettype none

package sxc_pkg;

    // defaults for the top-level parameters
    localparam int STACK_DEPTH_DEF = 64;
    localparam int LINE_BITS_DEF   = 20;

    // reported line numbers, open-form counts and warning totals saturate at these values
    localparam logic [19:0] OUT_LINE_MAX = 20'hFFFFF;
    localparam logic [6:0]  OPEN_MAX     = 7'd127;
    localparam logic [15:0] WARN_MAX     = 16'hFFFF;

    // head atom matcher codes
    localparam logic [2:0] MATCH_IDLE = 3'd0;
    localparam logic [2:0] MATCH_ONE  = 3'd1;
    localparam logic [2:0] MATCH_FULL = 3'd4;
    localparam logic [2:0] MATCH_FAIL = 3'd5;

    // uuid child counter limits
    localparam logic [1:0] KIDS_ONE = 2'd1;
    localparam logic [1:0] KIDS_MAX = 2'd3;

    // characters with a meaning of their own
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_I  = 8'h69;
    localparam logic [7:0] CH_LOW_D  = 8'h64;

    // event codes
    typedef enum logic [2:0] {
        EV_STRAY_CLOSE  = 3'd0,
        EV_OPEN_STRING  = 3'd1,
        EV_ATOM_OUTSIDE = 3'd2,
        EV_UNCLOSED     = 3'd3,
        EV_NO_FORM      = 3'd4,
        EV_TOO_DEEP     = 3'd5,
        EV_UUID_TWICE   = 3'd6,
        EV_END_REPORT   = 3'd7
    } ev_kind_t;

    // scanner mode flags
    typedef struct packed {
        logic halt;
        logic atom;
        logic esc;
        logic str;
    } scan_flags_t;

    // one result beat
    typedef struct packed {
        ev_kind_t    kind;
        logic [19:0] line;
        logic [6:0]  open;
        logic [15:0] warn;
        logic        passed;
    } res_t;

    // letters of the word uuid
    function automatic logic [7:0] uuid_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_LOW_U;
            3'd1:    c = CH_LOW_U;
            3'd2:    c = CH_LOW_I;
            3'd3:    c = CH_LOW_D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bytes that end an atom
    function automatic logic is_delim(input logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_OPEN, CH_CLOSE, CH_QUOTE};
    endfunction

endpackage

`default_nettype wire

### rtl/sexpr_structure_checker.sv
// top level of the s-expression structure checker
`default_nettype none

// Checks s-expression text streamed in one byte per beat, with tlast marking the
// end of a text (its data byte is ignored). A byte can be accepted in every clock
// while the output buffer has room; a result beat is registered in that buffer
// before it appears on the master side, and its two entries let input continue
// while a result waits. Bytes stop flowing only when both output entries are full.
// The two innermost open forms live in registers; deeper forms live in a single
// memory of STACK_DEPTH entries whose next entry below the parent is read ahead
// into its read register, so a close never waits. The memory needs no clearing
// after reset. The strict mode bit may be written only while no text is in flight.

module sexpr_structure_checker #(
    parameter int STACK_DEPTH = sxc_pkg::STACK_DEPTH_DEF,
    parameter int LINE_BITS   = sxc_pkg::LINE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // text byte beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    // event beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [19:0] event_line, [26:20] open_forms,
                                        // [42:27] warning_total, [43] text_passed
    output logic [2:0]       m_tuser,   // [2:0] event_kind
    // strict mode register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_data   // [0] strict_mode
);

    import sxc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int EW = LINE_BITS + 4;

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    res_t          m_res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    assign cfg_ready = 1'b1;

    sxc_scanner #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS),
        .AW          (AW),
        .DW          (DW),
        .EW          (EW)
    ) u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data[0]),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    sxc_stack_mem #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sxc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid && res_valid),
        .push_data  (res),
        .push_ready (res_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_res)
    );

    // pack the result beat
    assign m_tdata = {4'b0000, m_res.passed, m_res.warn, m_res.open, m_res.line};
    assign m_tuser = m_res.kind;

endmodule

`default_nettype wire

### rtl/sxc_stack_mem.sv
// synchronous form stack memory, one write and one registered read port with forwarding
`default_nettype none

module sxc_stack_mem #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, new data wins on an address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/sxc_out_buf.sv
// two-entry result buffer between the scanner and the master stream port
`default_nettype none

module sxc_out_buf (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    input  wire sxc_pkg::res_t   push_data,
    output logic                 push_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output sxc_pkg::res_t        m_data
);

    import sxc_pkg::*;

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_data_reg, main_data_next;
    res_t skid_data_reg, skid_data_next;
    logic pop;
    logic push;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && m_ready;

    // occupancy and data steering
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (pop || !main_valid_reg) begin
            main_valid_next = push;
            main_data_next  = push_data;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = main_valid_reg;
    assign m_data  = main_data_reg;

`ifndef SYNTH
    // the skid entry is only used behind a held main entry
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid without main entry");
`endif

endmodule

`default_nettype wire

### rtl/sxc_scanner.sv
// byte scanner: string, atom and line tracking, stack top and parent, event generation
`default_nettype none

module sxc_scanner #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 20,
    parameter int AW          = 6,
    parameter int DW          = 7,
    parameter int EW          = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // item beat
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    // result toward the output buffer
    output logic               res_valid,
    output sxc_pkg::res_t      res,
    input  wire logic          res_ready,
    // strict mode register write
    input  wire logic          cfg_valid,
    input  wire logic          cfg_data,
    // stack memory
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [EW-1:0]      wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  wire logic [EW-1:0] rd_data
);

    import sxc_pkg::*;

    typedef struct packed {
        logic [LINE_BITS-1:0] line;
        logic                 head_seen;
        logic                 head_uuid;
        logic [1:0]           kids;
    } entry_t;

    localparam logic [LINE_BITS-1:0] LINE_TOP   = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);
    localparam logic [DW-1:0]        DEPTH_FULL = DW'(STACK_DEPTH);

    logic                 strict_reg;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] str_line_reg, str_line_next;
    scan_flags_t          flags_reg, flags_next;
    logic [2:0]           match_reg, match_next;
    logic                 saw_reg, saw_next;
    logic [15:0]          warn_reg, warn_next;
    logic                 err_reg, err_next;
    entry_t               top_reg, top_next;
    entry_t               par_reg, par_next;
    entry_t               grand;
    entry_t               closed;
    logic                 fire;
    logic                 proceed;
    logic                 head_now;
    logic                 head_uuid_now;
    logic [LINE_BITS-1:0] res_line_raw;
    logic [32:0]          res_line_wide;
    logic [31:0]          depth_wide;

    assign in_ready = res_ready;
    assign fire     = in_valid && res_ready;
    assign grand    = entry_t'(rd_data);
    assign depth_wide = 32'(depth_reg);

    // next state and event for one beat
    always_comb begin
        depth_next    = depth_reg;
        line_next     = line_reg;
        str_line_next = str_line_reg;
        flags_next    = flags_reg;
        match_next    = match_reg;
        saw_next      = saw_reg;
        warn_next     = warn_reg;
        err_next      = err_reg;
        top_next      = top_reg;
        par_next      = par_reg;
        closed        = top_reg;
        proceed       = 1'b0;
        head_now      = 1'b0;
        head_uuid_now = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = AW'(depth_reg - DW'(2));
        wr_data       = EW'(par_reg);
        res_valid     = 1'b0;
        res.kind      = EV_END_REPORT;
        res_line_raw  = line_reg;
        res.open      = 7'd0;
        res.warn      = warn_reg;
        res.passed    = 1'b0;

        if (in_last) begin
            // end of text: verdict, then clear the per-text state
            res_valid = 1'b1;
            if (flags_reg.halt) begin
                res.kind = EV_END_REPORT;
            end else if (flags_reg.str) begin
                res.kind     = EV_OPEN_STRING;
                res_line_raw = str_line_reg;
            end else if (depth_reg != '0) begin
                res.kind     = EV_UNCLOSED;
                res_line_raw = top_reg.line;
                res.open     = (depth_wide > 32'(OPEN_MAX)) ? OPEN_MAX : depth_wide[6:0];
            end else if (!saw_reg) begin
                res.kind     = EV_NO_FORM;
                res_line_raw = LINE_FIRST;
            end else begin
                res.kind   = EV_END_REPORT;
                res.passed = !err_reg && !(strict_reg && (warn_reg != '0));
            end
            depth_next    = '0;
            line_next     = LINE_FIRST;
            str_line_next = LINE_FIRST;
            flags_next    = '0;
            match_next    = MATCH_IDLE;
            saw_next      = 1'b0;
            warn_next     = '0;
            err_next      = 1'b0;
        end else if (!flags_reg.halt) begin
            if (flags_reg.str) begin
                // inside a string
                if (flags_reg.esc) begin
                    flags_next.esc = 1'b0;
                    if ((in_byte == CH_LF) && (line_reg != LINE_TOP)) begin
                        line_next = line_reg + LINE_FIRST;
                    end
                end else if (in_byte == CH_BSLASH) begin
                    flags_next.esc = 1'b1;
                end else if (in_byte == CH_QUOTE) begin
                    flags_next.str = 1'b0;
                    head_now       = 1'b1;
                end else if ((in_byte == CH_LF) && (line_reg != LINE_TOP)) begin
                    line_next = line_reg + LINE_FIRST;
                end
            end else begin
                proceed = 1'b1;
                // atom continues or ends here
                if (flags_reg.atom) begin
                    if (!is_delim(in_byte)) begin
                        proceed = 1'b0;
                        if ((match_reg < MATCH_FULL) && (in_byte == uuid_char(match_reg))) begin
                            match_next = match_reg + 3'd1;
                        end else begin
                            match_next = MATCH_FAIL;
                        end
                    end else begin
                        flags_next.atom = 1'b0;
                        head_now        = 1'b1;
                        head_uuid_now   = (match_reg == MATCH_FULL);
                        match_next      = MATCH_IDLE;
                    end
                end
            end

            // first atom or string of a form becomes its head
            if (head_now && (depth_reg != '0) && !top_reg.head_seen) begin
                top_next.head_seen = 1'b1;
                top_next.head_uuid = head_uuid_now;
            end

            if (proceed) begin
                case (in_byte)
                    CH_LF: begin
                        if (line_reg != LINE_TOP) begin
                            line_next = line_reg + LINE_FIRST;
                        end
                    end
                    CH_SPACE, CH_TAB, CH_CR: begin
                    end
                    CH_OPEN: begin
                        if (depth_reg >= DEPTH_FULL) begin
                            err_next        = 1'b1;
                            flags_next.halt = 1'b1;
                            res_valid       = 1'b1;
                            res.kind        = EV_TOO_DEEP;
                        end else begin
                            // parent spills to memory, top becomes parent
                            if (depth_reg == '0) begin
                                saw_next = 1'b1;
                            end
                            wr_en              = fire && (depth_reg >= DW'(2));
                            par_next           = top_next;
                            top_next.line      = line_reg;
                            top_next.head_seen = 1'b0;
                            top_next.head_uuid = 1'b0;
                            top_next.kids      = 2'd0;
                            depth_next         = depth_reg + DW'(1);
                        end
                    end
                    CH_CLOSE: begin
                        if (depth_reg == '0) begin
                            err_next        = 1'b1;
                            flags_next.halt = 1'b1;
                            res_valid       = 1'b1;
                            res.kind        = EV_STRAY_CLOSE;
                        end else begin
                            // parent becomes top, prefetched entry becomes parent
                            closed     = top_next;
                            depth_next = depth_reg - DW'(1);
                            top_next   = par_reg;
                            par_next   = grand;
                            if (closed.head_uuid && (depth_reg >= DW'(2))) begin
                                if (par_reg.kids != KIDS_MAX) begin
                                    top_next.kids = par_reg.kids + 2'd1;
                                end
                                if (par_reg.kids == KIDS_ONE) begin
                                    if (warn_reg != WARN_MAX) begin
                                        warn_next = warn_reg + 16'd1;
                                    end
                                    res_valid    = 1'b1;
                                    res.kind     = EV_UUID_TWICE;
                                    res_line_raw = closed.line;
                                    res.warn     = warn_next;
                                end
                            end
                        end
                    end
                    CH_QUOTE: begin
                        flags_next.str = 1'b1;
                        flags_next.esc = 1'b0;
                        str_line_next  = line_reg;
                    end
                    default: begin
                        // first byte of an atom
                        if (depth_reg == '0) begin
                            err_next        = 1'b1;
                            flags_next.halt = 1'b1;
                            res_valid       = 1'b1;
                            res.kind        = EV_ATOM_OUTSIDE;
                        end else begin
                            flags_next.atom = 1'b1;
                            match_next      = (in_byte == CH_LOW_U) ? MATCH_ONE : MATCH_FAIL;
                        end
                    end
                endcase
            end
        end

        // saturate the reported line
        res_line_wide = 33'(res_line_raw);
        res.line      = (res_line_wide > 33'(OUT_LINE_MAX)) ? OUT_LINE_MAX
                                                             : res_line_wide[19:0];
    end

    // prefetch the entry below the new parent
    assign rd_en   = fire && (depth_next >= DW'(3));
    assign rd_addr = AW'(depth_next - DW'(3));

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= '0;
            line_reg     <= LINE_FIRST;
            str_line_reg <= LINE_FIRST;
            flags_reg    <= '0;
            match_reg    <= MATCH_IDLE;
            saw_reg      <= 1'b0;
            warn_reg     <= '0;
            err_reg      <= 1'b0;
        end else if (fire) begin
            depth_reg    <= depth_next;
            line_reg     <= line_next;
            str_line_reg <= str_line_next;
            flags_reg    <= flags_next;
            match_reg    <= match_next;
            saw_reg      <= saw_next;
            warn_reg     <= warn_next;
            err_reg      <= err_next;
        end
    end

    // top and parent entries
    always_ff @(posedge aclk) begin
        if (fire) begin
            top_reg <= top_next;
            par_reg <= par_next;
        end
    end

    // strict mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b0;
        end else if (cfg_valid) begin
            strict_reg <= cfg_data;
        end
    end

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth beyond capacity");

    a_halt_has_error: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.halt |-> err_reg)
        else $error("scan halted without an error");

    a_escape_in_string: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.esc |-> flags_reg.str)
        else $error("escape pending outside a string");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_last) |=> ((depth_reg == '0) && (flags_reg == '0) && !err_reg))
        else $error("end of text did not clear the scan state");
`endif

endmodule

`default_nettype wire
